>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

>>> hw/rtl/lsp_pkg.sv
// Package for the LRU slot pool: constants, types and state encoding.
`timescale 1ns / 1ps

package lsp_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int SLOT_IDX_W     = 4;
    localparam int DOC_W          = 32;
    localparam int STAMP_W        = 32;
    localparam int CNT_W          = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } lsp_state_t;

    typedef enum logic {
        OP_LOOKUP  = 1'b0,
        OP_RELEASE = 1'b1
    } lsp_op_t;

    typedef struct packed {
        logic match;
        logic older;
    } lsp_cmp_t;

endpackage

>>> hw/rtl/lsp_cmp_unit.sv
// Shared compare unit: id match and stamp age test for one slot per cycle.
`timescale 1ns / 1ps

module lsp_cmp_unit
(
    input  logic [lsp_pkg::DOC_W-1:0]   slot_doc,
    input  logic [lsp_pkg::STAMP_W-1:0] slot_stamp,
    input  logic [lsp_pkg::DOC_W-1:0]   key,
    input  logic [lsp_pkg::STAMP_W-1:0] best_stamp,
    output lsp_pkg::lsp_cmp_t           res
);
    import lsp_pkg::*;

    always_comb
    begin
        res.match = (slot_doc == key);
        res.older = (slot_stamp < best_stamp);
    end

endmodule

>>> hw/rtl/lru_slot_pool_top.sv
// Top level of the LRU slot pool: slot store, scan sequencer and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Fully associative pool of SLOT_COUNT slots with LRU replacement by stamp.
// Input word (s_axis): tdata = doc_id, tuser = {canvas_empty, opcode}.
//   opcode 0 looks up doc_id, opcode 1 releases every slot and the serial.
// Output word (m_axis): one per input word, fields listed at the port.
// A lookup scans the slots one per cycle through a single compare unit,
// tracking the first id match and the oldest stamp, then commits.
// Release and refused lookups skip the scan and go straight to commit.
// s_axis_tready is high only while the sequencer is idle; one word is in
// work at a time. The result register decouples the output: a new word is
// taken while a result waits, and the commit stalls until it drains.
// Reset empties all slots and clears the serial and eviction count.
module lru_slot_pool_top
#(
    parameter int SLOT_COUNT = lsp_pkg::SLOT_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // doc_id
    input  logic [1:0]  s_axis_tuser,   // opcode, canvas_empty
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // granted, slot_index[3:0], hit, evicted, evicted_id[31:0],
    // eviction_total[31:0], zero pad
    output logic [71:0] m_axis_tdata
);
    import lsp_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    lsp_state_t state_reg, state_next;

    logic [DOC_W-1:0]   slot_doc_reg   [SLOT_COUNT];
    logic [STAMP_W-1:0] slot_stamp_reg [SLOT_COUNT];
    logic [STAMP_W-1:0] use_serial_reg;
    logic [CNT_W-1:0]   evict_cnt_reg;

    logic [DOC_W-1:0]   key_reg;
    logic               refuse_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [DOC_W-1:0]   best_doc_reg;

    logic               out_valid_reg;
    logic               out_granted_reg;
    logic [SLOT_IDX_W-1:0] out_idx_reg;
    logic               out_hit_reg;
    logic               out_evicted_reg;
    logic [DOC_W-1:0]   out_ev_id_reg;
    logic [CNT_W-1:0]   out_total_reg;

    logic               in_acc;
    logic               is_release;
    logic               out_free;
    logic               do_clear;
    logic               do_scan;
    logic               do_commit;
    logic               last_slot;
    lsp_cmp_t           cmp;
    logic               grant;
    logic [IDX_W-1:0]   pick;
    logic               evict;
    logic [STAMP_W-1:0] serial_next;
    logic [CNT_W-1:0]   evict_cnt_next;

    lsp_cmp_unit u_cmp
    (
        .slot_doc   (slot_doc_reg[scan_idx_reg]),
        .slot_stamp (slot_stamp_reg[scan_idx_reg]),
        .key        (key_reg),
        .best_stamp (best_stamp_reg),
        .res        (cmp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_release    = (s_axis_tuser[0] == OP_RELEASE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign last_slot     = (scan_idx_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!is_release && !s_axis_tuser[1])
                        state_next = ST_SCAN;
                    else
                        state_next = ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (last_slot)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        do_clear  = 1'b0;
        do_scan   = 1'b0;
        do_commit = 1'b0;
        case (state_reg)
            ST_IDLE:   do_clear  = in_acc && is_release;
            ST_SCAN:   do_scan   = 1'b1;
            ST_COMMIT: do_commit = out_free;
            default:   do_clear  = 1'b0;
        endcase
    end

    assign grant          = !refuse_reg;
    assign pick           = found_reg ? hit_idx_reg : best_idx_reg;
    assign evict          = grant && !found_reg && (best_doc_reg != '0);
    assign serial_next    = (use_serial_reg == STAMP_MAX) ? use_serial_reg
                                                          : use_serial_reg + 1'b1;
    assign evict_cnt_next = (evict && evict_cnt_reg != CNT_MAX) ? evict_cnt_reg + 1'b1
                                                                : evict_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // request capture and scan tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg        <= '0;
            refuse_reg     <= 1'b0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            hit_idx_reg    <= '0;
            best_idx_reg   <= '0;
            best_stamp_reg <= '0;
            best_doc_reg   <= '0;
        end
        else if (in_acc)
        begin
            key_reg      <= s_axis_tdata;
            refuse_reg   <= is_release || s_axis_tuser[1];
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            hit_idx_reg  <= '0;
        end
        else if (do_scan)
        begin
            if (!found_reg && cmp.match)
            begin
                found_reg   <= 1'b1;
                hit_idx_reg <= scan_idx_reg;
            end
            if (scan_idx_reg == '0 || cmp.older)
            begin
                best_idx_reg   <= scan_idx_reg;
                best_stamp_reg <= slot_stamp_reg[scan_idx_reg];
                best_doc_reg   <= slot_doc_reg[scan_idx_reg];
            end
            if (!last_slot)
                scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    // slot store, serial and eviction count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_doc_reg[i]   <= '0;
                slot_stamp_reg[i] <= '0;
            end
            use_serial_reg <= '0;
            evict_cnt_reg  <= '0;
        end
        else if (do_clear)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_doc_reg[i]   <= '0;
                slot_stamp_reg[i] <= '0;
            end
            use_serial_reg <= '0;
        end
        else if (do_commit && grant)
        begin
            slot_stamp_reg[pick] <= serial_next;
            if (!found_reg)
                slot_doc_reg[pick] <= key_reg;
            use_serial_reg <= serial_next;
            evict_cnt_reg  <= evict_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_granted_reg <= 1'b0;
            out_idx_reg     <= '0;
            out_hit_reg     <= 1'b0;
            out_evicted_reg <= 1'b0;
            out_ev_id_reg   <= '0;
            out_total_reg   <= '0;
        end
        else if (do_commit)
        begin
            out_valid_reg   <= 1'b1;
            out_granted_reg <= grant;
            out_idx_reg     <= grant ? SLOT_IDX_W'(pick) : '0;
            out_hit_reg     <= grant && found_reg;
            out_evicted_reg <= evict;
            out_ev_id_reg   <= evict ? best_doc_reg : '0;
            out_total_reg   <= evict_cnt_next;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_total_reg, out_ev_id_reg, out_evicted_reg,
                            out_hit_reg, out_idx_reg, out_granted_reg};

    `ASSERT_NEVER(a_hit_and_evict, out_valid_reg && out_hit_reg && out_evicted_reg,
        "result reports both hit and eviction")
    `ASSERT_CLK(a_accept_leaves_idle, in_acc |=> (state_reg != ST_IDLE),
        "sequencer stayed idle after accepting a word")
    `ASSERT_CLK(a_release_clears_serial, (in_acc && is_release) |=> (use_serial_reg == '0),
        "serial not cleared by release")
    `ASSERT_CLK(a_evict_cnt_monotonic, 1'b1 |=> (evict_cnt_reg >= $past(evict_cnt_reg)),
        "eviction count decreased")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the LRU slot pool top level.
`timescale 1ns / 1ps

module tb_top;
    import lsp_pkg::*;

    localparam int NSLOT          = SLOT_COUNT_DEF;
    localparam int RANDOM_WORDS   = 1700;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 4 * (NSLOT + 2);
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 120;
    localparam int WORKING_IDS    = 6;

    typedef struct {
        bit          drain;      // pause until every pending grant is back
        lsp_op_t     op;
        logic [31:0] doc;
        logic        no_canvas;
    } lookup_req_t;

    typedef struct {
        logic        granted;
        logic [3:0]  slot;
        logic        hit;
        logic        evicted;
        logic [31:0] evicted_doc;
        logic [31:0] evict_total;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    lru_slot_pool_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // shadow pool
    logic [31:0] pool_doc[NSLOT] = '{default: '0};
    logic [31:0] pool_stamp[NSLOT] = '{default: '0};
    logic [31:0] pool_serial = '0;
    logic [31:0] pool_evictions = '0;

    lookup_req_t pend_q[$];
    grant_t      grant_q[$];

    int err_count = 0;
    int cycles = 0;
    int words_in = 0;
    int words_out = 0;
    int n_hit = 0;
    int n_evict = 0;
    int n_release = 0;
    int n_refused = 0;

    function automatic grant_t pool_predict(lookup_req_t r);
        grant_t g;
        int     i;
        int     pick;
        bit     found;
        g = '{default: '0};
        pick = 0;
        found = 1'b0;
        if (r.op == OP_RELEASE) begin
            for (i = 0; i < NSLOT; i++) begin
                pool_doc[i] = '0;
                pool_stamp[i] = '0;
            end
            pool_serial = '0;
            n_release++;
        end
        else if (r.no_canvas) begin
            n_refused++;
        end
        else begin
            for (i = 0; i < NSLOT; i++) begin
                if (!found && pool_doc[i] == r.doc) begin
                    pick = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                for (i = 1; i < NSLOT; i++) begin
                    if (pool_stamp[i] < pool_stamp[pick])
                        pick = i;
                end
                if (pool_doc[pick] != '0) begin
                    g.evicted = 1'b1;
                    g.evicted_doc = pool_doc[pick];
                    if (pool_evictions != '1)
                        pool_evictions++;
                    n_evict++;
                end
                pool_doc[pick] = r.doc;
            end
            else begin
                n_hit++;
            end
            if (pool_serial != '1)
                pool_serial++;
            pool_stamp[pick] = pool_serial;
            g.granted = 1'b1;
            g.slot = pick[3:0];
            g.hit = found;
        end
        g.evict_total = pool_evictions;
        return g;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            err_count++;
        end
    endtask

    task automatic add_word(lsp_op_t op, logic [31:0] doc, logic no_canvas);
        lookup_req_t r;
        r.drain = 1'b0;
        r.op = op;
        r.doc = doc;
        r.no_canvas = no_canvas;
        pend_q.insert(pend_q.size(), r);
    endtask

    task automatic add_drain();
        lookup_req_t r;
        r = '{drain: 1'b1, op: OP_LOOKUP, doc: '0, no_canvas: 1'b0};
        pend_q.insert(pend_q.size(), r);
    endtask

    // sender
    lookup_req_t cur_req;
    bit          offering = 1'b0;
    int          send_gap = 0;
    bit          send_calm = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            offering = 1'b0;
            send_gap = 0;
        end
        else begin
            if (offering && s_axis_tready) begin
                grant_q.insert(grant_q.size(), pool_predict(cur_req));
                offering = 1'b0;
                words_in++;
            end
            if (!offering && pend_q.size() > 0) begin
                if (pend_q[0].drain) begin
                    if (grant_q.size() == 0)
                        pend_q.delete(0);
                end
                else if (send_gap > 0) begin
                    send_gap--;
                end
                else begin
                    cur_req = pend_q.pop_front();
                    s_axis_tdata <= cur_req.doc;
                    s_axis_tuser <= {cur_req.no_canvas, cur_req.op};
                    offering = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 6);
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // receiver and checker
    grant_t exp_grant;
    int     recv_stall = 0;
    int     hold_left = 0;
    bit     recv_calm = 1'b0;
    logic   rdy;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
            hold_left = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (grant_q.size() == 0) begin
                    $error("result word with no expectation: %h", m_axis_tdata);
                    err_count++;
                end
                else begin
                    exp_grant = grant_q.pop_front();
                    check_field("granted", 32'(exp_grant.granted), 32'(m_axis_tdata[0]));
                    check_field("slot_index", 32'(exp_grant.slot), 32'(m_axis_tdata[4:1]));
                    check_field("hit", 32'(exp_grant.hit), 32'(m_axis_tdata[5]));
                    check_field("evicted", 32'(exp_grant.evicted), 32'(m_axis_tdata[6]));
                    check_field("evicted_id", exp_grant.evicted_doc, m_axis_tdata[38:7]);
                    check_field("eviction_total", exp_grant.evict_total,
                                m_axis_tdata[70:39]);
                end
                words_out++;
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                recv_stall = recv_calm ? 0 : $urandom_range(0, 6);
                if (words_out == HOLDOFF_AT)
                    hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (recv_stall > 0) begin
                if (m_axis_tvalid)
                    recv_stall--;
                rdy = 1'b0;
            end
            else begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d grants outstanding", cycles,
                     grant_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [31:0] ids[WORKING_IDS];
        logic [31:0] doc;
        int          i;
        int          roll;

        // directed: empty pool, refusals, fill, hits, evictions, id zero, releases
        add_word(OP_LOOKUP, 32'h0000_0000, 1'b0);
        add_word(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        add_word(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1);
        add_word(OP_LOOKUP, 32'h1234_5678, 1'b1);
        add_word(OP_LOOKUP, 32'hA5A5_A5A5, 1'b0);
        add_word(OP_LOOKUP, 32'h5A5A_5A5A, 1'b0);
        add_word(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        add_word(OP_LOOKUP, 32'h0000_0001, 1'b0);
        add_word(OP_LOOKUP, 32'h8000_0000, 1'b0);
        add_word(OP_LOOKUP, 32'h0000_0000, 1'b0);
        add_word(OP_LOOKUP, 32'h0000_0000, 1'b0);
        add_word(OP_LOOKUP, 32'hA5A5_A5A5, 1'b0);
        add_drain();
        add_word(OP_RELEASE, 32'hDEAD_BEEF, 1'b1);
        add_word(OP_LOOKUP, 32'h8000_0000, 1'b0);
        add_word(OP_RELEASE, 32'h0000_0000, 1'b0);
        add_word(OP_RELEASE, 32'hFFFF_FFFF, 1'b0);
        add_word(OP_LOOKUP, 32'h7FFF_FFFF, 1'b0);
        add_word(OP_LOOKUP, 32'h7FFF_FFFF, 1'b0);
        add_word(OP_LOOKUP, 32'h0000_0000, 1'b1);
        add_drain();

        // random: mostly a small working set so hits and evictions both occur
        for (i = 0; i < WORKING_IDS; i++)
            ids[i] = $urandom;
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 19) == 0)
                ids[$urandom_range(0, WORKING_IDS - 1)] = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 10)
                doc = '0;
            else if (roll < 30)
                doc = $urandom;
            else
                doc = ids[$urandom_range(0, WORKING_IDS - 1)];
            if ($urandom_range(0, 49) == 0) begin
                if ($urandom_range(0, 2) == 0)
                    add_drain();
                add_word(OP_RELEASE, doc, logic'($urandom_range(0, 1)));
            end
            else begin
                add_word(OP_LOOKUP, doc, ($urandom_range(0, 11) == 0));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() > 0 || offering || grant_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d words in, %0d results: %0d hits, %0d evictions, %0d releases, %0d refused",
                 words_in, words_out, n_hit, n_evict, n_release, n_refused);
        $display("receiver held off %0d cycles at result %0d; sender drained on each pause",
                 HOLDOFF_CYCLES, HOLDOFF_AT);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
